// ===== src/mic_pkg.sv =====
// Shared types and constants for the MIPS I integer core.
`default_nettype none
package mic_pkg;

  localparam logic [1:0] KIND_FETCH   = 2'd0;
  localparam logic [1:0] KIND_LOAD    = 2'd1;
  localparam logic [1:0] KIND_STORE   = 2'd2;
  localparam logic [1:0] KIND_SYSCALL = 2'd3;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_SP    = 2'd1;
  localparam logic [1:0] REG_GP    = 2'd2;

  localparam logic [4:0] R_V0 = 5'd2;
  localparam logic [4:0] R_GP = 5'd28;
  localparam logic [4:0] R_SP = 5'd29;
  localparam logic [4:0] R_RA = 5'd31;

  // datapath operation requested by the controller
  typedef struct packed {
    logic exec;      // run the decoded instruction
    logic load_done; // merge load data into its register
    logic md_start;  // start multiply/divide unit
    logic emit2;     // emit the second (fetch) beat of a pair
  } dp_cmd_t;

  typedef struct packed {
    logic is_mul;    // instruction is mult/multu
    logic is_div;    // instruction is div/divu
    logic md_busy;
    logic md_done;
    logic two_beat;  // store or syscall: two result beats
    logic is_load;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/mic_muldiv.sv =====
// Iterative multiply/divide unit: one bit per cycle.
`default_nettype none
module mic_muldiv import mic_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        is_div,
  input  wire logic        sgn,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             busy,
  output logic             done,
  output logic             wr,
  output logic [31:0]      hi,
  output logic [31:0]      lo
);
  logic [5:0]  cnt;
  logic        div_mode, neg_q, neg_r, skip;
  logic [31:0] divisor;
  logic [63:0] acc;       // mul: product accumulator; div: remainder:quotient
  logic [32:0] trial;
  logic [32:0] psum;
  logic [31:0] ua, ub;
  logic [31:0] q_fix, r_fix;
  logic [63:0] prod;

  assign ua = (sgn && a[31]) ? 32'd0 - a : a;
  assign ub = (sgn && b[31]) ? 32'd0 - b : b;
  assign trial = {acc[63:31]} - {1'b0, divisor};
  assign psum = {1'b0, acc[63:32]} + (acc[0] ? {1'b0, divisor} : 33'd0);
  assign q_fix = neg_q ? 32'd0 - acc[31:0] : acc[31:0];
  assign r_fix = neg_r ? 32'd0 - acc[63:32] : acc[63:32];

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= 6'd32;
      div_mode <= is_div;
      skip     <= is_div && (b == 32'd0);
      neg_q    <= sgn && (a[31] ^ b[31]);
      neg_r    <= sgn && a[31];
      divisor  <= is_div ? ub : ua;
      acc      <= is_div ? {32'd0, ua} : {32'd0, ub};
    end else if (busy) begin
      if (cnt == 6'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 6'd1;
        if (div_mode) begin
          if (!trial[32]) acc <= {trial[31:0], acc[30:0], 1'b1};
          else            acc <= {acc[62:0], 1'b0};
        end else begin
          // shift-add on magnitudes, multiplier in low half
          acc <= {psum, acc[31:1]};
        end
      end
    end
  end

  // signed product sign: neg_q holds a^b sign
  assign prod = neg_q ? 64'd0 - acc : acc;
  assign wr = done && !(div_mode && skip);
  assign hi = div_mode ? r_fix : prod[63:32];
  assign lo = div_mode ? q_fix : prod[31:0];
endmodule
`default_nettype wire

// ===== src/mic_datapath.sv =====
// Datapath: register file, HI/LO, PC, decode/execute and result formation.
`default_nettype none
module mic_datapath import mic_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [31:0] cfg_val,
  input  wire logic [31:0] instruction_word,
  input  wire logic [31:0] read_data,
  output logic [1:0]       r_kind,
  output logic [31:0]      r_address,
  output logic [31:0]      r_write_data,
  output logic [3:0]       r_byte_enable,
  output logic             r_last,
  output logic [1:0]       r2_kind_unused
);
  logic [31:0] regs [32];
  logic [31:0] hi_r, lo_r, pc, delay_target;
  logic        delay_pending;
  logic [4:0]  ld_dst;
  logic [2:0]  ld_fmt;
  logic [1:0]  ld_off;

  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sa;
  logic [31:0] a, b, imm, simm, btgt, addr, nxt, tgt, wval, wdata;
  logic [4:0]  widx;
  logic        wen, take, annul;
  logic [1:0]  mem, k;
  logic [3:0]  be;
  logic [4:0]  s;
  logic        md_busy, md_done, md_wr;
  logic [31:0] md_hi, md_lo;

  assign op = instruction_word[31:26];
  assign rs = instruction_word[25:21];
  assign rt = instruction_word[20:16];
  assign rd = instruction_word[15:11];
  assign sa = instruction_word[10:6];
  assign fn = instruction_word[5:0];
  assign imm  = {16'd0, instruction_word[15:0]};
  assign simm = {{16{instruction_word[15]}}, instruction_word[15:0]};
  assign a = (rs == 5'd0) ? 32'd0 : regs[rs];
  assign b = (rt == 5'd0) ? 32'd0 : regs[rt];
  assign btgt = pc + 32'd4 + {simm[29:0], 2'b00};
  assign addr = a + simm;
  assign k = addr[1:0];
  assign s = a[4:0];

  always_comb begin
    wen = 1'b0; widx = rd; wval = '0; take = 1'b0; annul = 1'b0;
    tgt = btgt; mem = 2'd0; be = 4'd0; wdata = '0;
    case (op)
      6'd0: begin
        wen = 1'b1;
        case (fn)
          6'd0:  wval = b << sa;
          6'd2:  wval = b >> sa;
          6'd3:  wval = $signed(b) >>> sa;
          6'd4:  wval = b << s;
          6'd6:  wval = b >> s;
          6'd7:  wval = $signed(b) >>> s;
          6'd8:  begin wen = 1'b0; take = 1'b1; tgt = a; end
          6'd9:  begin take = 1'b1; tgt = a; wval = pc + 32'd8; end
          6'd12: begin wen = 1'b0; mem = 2'd3; end
          6'd16: wval = hi_r;
          6'd18: wval = lo_r;
          6'd32, 6'd33: wval = a + b;
          6'd34, 6'd35: wval = a - b;
          6'd36: wval = a & b;
          6'd37: wval = a | b;
          6'd38: wval = a ^ b;
          6'd39: wval = ~(a | b);
          6'd42: wval = {31'd0, $signed(a) < $signed(b)};
          6'd43: wval = {31'd0, a < b};
          default: wen = 1'b0;
        endcase
      end
      6'd1: begin
        if (rt == 5'd0 || rt == 5'd16) take = a[31];
        else if (rt == 5'd1 || rt == 5'd17) take = !a[31];
        if (rt == 5'd16 || rt == 5'd17) begin
          wen = 1'b1; widx = R_RA; wval = pc + 32'd8;
        end
      end
      6'd2, 6'd3: begin
        take = 1'b1;
        tgt = {(pc + 32'd4) & 32'hF000_0000} | {4'd0, instruction_word[25:0], 2'b00};
        if (op == 6'd3) begin wen = 1'b1; widx = R_RA; wval = pc + 32'd8; end
      end
      6'd4: take = (a == b);
      6'd5: take = (a != b);
      6'd6: take = (a == 32'd0) || a[31];
      6'd7: take = !((a == 32'd0) || a[31]);
      6'd8, 6'd9:   begin wen = 1'b1; widx = rt; wval = a + simm; end
      6'd10: begin wen = 1'b1; widx = rt; wval = {31'd0, $signed(a) < $signed(simm)}; end
      6'd11: begin wen = 1'b1; widx = rt; wval = {31'd0, a < simm}; end
      6'd12: begin wen = 1'b1; widx = rt; wval = a & imm; end
      6'd13: begin wen = 1'b1; widx = rt; wval = a | imm; end
      6'd14: begin wen = 1'b1; widx = rt; wval = a ^ imm; end
      6'd15: begin wen = 1'b1; widx = rt; wval = {instruction_word[15:0], 16'd0}; end
      6'd20, 6'd21, 6'd22: begin
        if (op == 6'd20) take = (a == b);
        else if (op == 6'd21) take = (a != b);
        else take = (a == 32'd0) || a[31];
        annul = !take;
      end
      6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38: mem = 2'd1;
      6'd40: begin mem = 2'd2; be = 4'b1000 >> k; wdata = {b[7:0], 24'd0} >> {k, 3'b000}; end
      6'd41: begin
        mem = 2'd2;
        if (k[1]) begin be = 4'b0011; wdata = {16'd0, b[15:0]}; end
        else begin be = 4'b1100; wdata = {b[15:0], 16'd0}; end
      end
      6'd42: begin mem = 2'd2; be = 4'b1111 >> k; wdata = b >> {k, 3'b000}; end
      6'd43: begin mem = 2'd2; be = 4'b1111; wdata = b; end
      6'd46: begin
        mem = 2'd2; be = 4'b1111 << (2'd3 - k);
        wdata = b << {2'd3 - k, 3'b000};
      end
      default: ;
    endcase
  end

  assign nxt = (delay_pending ? delay_target : pc + 32'd4) + (annul ? 32'd4 : 32'd0);

  // load merge
  logic [7:0]  byt;
  logic [15:0] half;
  logic [31:0] old, lval, msk;
  assign byt  = read_data[{~ld_off, 3'b000} +: 8];
  assign half = ld_off[1] ? read_data[15:0] : read_data[31:16];
  assign old  = regs[ld_dst];
  always_comb begin
    msk = '0;
    case (ld_fmt)
      3'd0: lval = {{24{byt[7]}}, byt};
      3'd1: lval = {{16{half[15]}}, half};
      3'd2: begin
        msk  = 32'hFFFF_FFFF >> {~ld_off + 2'd1, 3'b000};
        lval = (ld_off == 2'd0) ? read_data :
               ((read_data << {ld_off, 3'b000}) | (old & msk));
      end
      3'd4: lval = {24'd0, byt};
      3'd5: lval = {16'd0, half};
      3'd6: begin
        msk  = ~(32'hFFFF_FFFF >> {~ld_off, 3'b000});
        lval = (ld_off == 2'd3) ? read_data :
               ((read_data >> {~ld_off, 3'b000}) | (old & msk));
      end
      default: lval = read_data;
    endcase
  end

  logic is_md, md_sgn;
  assign is_md  = (op == 6'd0) && (fn == 6'd24 || fn == 6'd25 || fn == 6'd26 || fn == 6'd27);
  assign md_sgn = !fn[0];

  mic_muldiv u_md (
    .clk, .rst, .start(cmd.md_start), .is_div(fn[1]), .sgn(md_sgn), .a, .b,
    .busy(md_busy), .done(md_done), .wr(md_wr), .hi(md_hi), .lo(md_lo)
  );

  assign stat.is_mul   = is_md && !fn[1];
  assign stat.is_div   = is_md && fn[1];
  assign stat.md_busy  = md_busy;
  assign stat.md_done  = md_done;
  assign stat.two_beat = (mem == 2'd2) || (mem == 2'd3);
  assign stat.is_load  = (mem == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) regs[i] <= '0;
      hi_r <= '0; lo_r <= '0; pc <= '0; delay_target <= '0;
      delay_pending <= 1'b0; ld_dst <= '0; ld_fmt <= '0; ld_off <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_START: begin regs[R_RA] <= cfg_val; pc <= cfg_val; end
          REG_SP:    regs[R_SP] <= cfg_val;
          REG_GP:    regs[R_GP] <= cfg_val;
          default: ;
        endcase
      end
      if (md_wr) begin hi_r <= md_hi; lo_r <= md_lo; end
      if (cmd.load_done && ld_dst != 5'd0) regs[ld_dst] <= lval;
      if (cmd.exec) begin
        if (wen && widx != 5'd0) regs[widx] <= wval;
        if (op == 6'd0 && fn == 6'd17) hi_r <= a;
        if (op == 6'd0 && fn == 6'd19) lo_r <= a;
        pc <= nxt;
        delay_pending <= take;
        if (take) delay_target <= tgt;
        if (mem == 2'd1) begin
          ld_dst <= rt; ld_fmt <= op[2:0]; ld_off <= k;
        end
      end
    end
  end

  // result beat, registered
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      r_last <= 1'b1; r_write_data <= '0; r_byte_enable <= '0;
      case (mem)
        2'd1: begin r_kind <= KIND_LOAD; r_address <= {addr[31:2], 2'b00}; end
        2'd2: begin
          r_kind <= KIND_STORE; r_address <= {addr[31:2], 2'b00};
          r_write_data <= wdata; r_byte_enable <= be; r_last <= 1'b0;
        end
        2'd3: begin
          r_kind <= KIND_SYSCALL; r_address <= '0; r_write_data <= regs[R_V0];
          r_last <= 1'b0;
        end
        default: begin r_kind <= KIND_FETCH; r_address <= nxt; end
      endcase
    end else if (cmd.load_done || cmd.emit2) begin
      r_kind <= KIND_FETCH; r_address <= pc; r_write_data <= '0;
      r_byte_enable <= '0; r_last <= 1'b1;
    end
  end
  assign r2_kind_unused = r_kind;
endmodule
`default_nettype wire

// ===== src/mic_ctrl.sv =====
// Controller: sequences accept, multiply/divide wait and result beats.
`default_nettype none
module mic_ctrl import mic_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic action,
  input  dp_stat_t  stat,
  input  wire logic out_fire,
  output dp_cmd_t   cmd,
  output logic      in_ready,
  output logic      out_valid
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MD   = 3'd1;
  localparam logic [2:0] S_OUT  = 3'd2;
  localparam logic [2:0] S_OUT2 = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;
  localparam logic [2:0] S_LOUT = 3'd5;

  logic [2:0] state, state_next;
  logic       waiting;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE, S_LOAD: if (in_fire) begin
        if (action && state == S_LOAD) begin
          cmd.load_done = 1'b1; state_next = S_LOUT;
        end else if (!action && state == S_IDLE) begin
          cmd.exec = 1'b1;
          if (stat.is_mul || stat.is_div) begin
            cmd.md_start = 1'b1; state_next = S_MD;
          end else state_next = stat.two_beat ? S_OUT2 : S_OUT;
        end
      end
      S_MD: if (stat.md_done) state_next = S_OUT;
      S_OUT: if (out_fire) state_next = waiting ? S_LOAD : S_IDLE;
      S_OUT2: if (out_fire) begin cmd.emit2 = 1'b1; state_next = S_OUT; end
      S_LOUT: if (out_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; waiting <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) waiting <= stat.is_load;
      if (cmd.load_done) waiting <= 1'b0;
    end
  end

  assign in_ready  = (state == S_IDLE) || (state == S_LOAD);
  assign out_valid = (state == S_OUT) || (state == S_OUT2) || (state == S_LOUT);
endmodule
`default_nettype wire

// ===== src/mips_integer_core_step.sv =====
// MIPS I integer core, one instruction word or load reply per input beat.
// The result beat is registered in the cycle after accept; multiply/divide first wait for the unit.
// A new input is taken only after the last result beat is taken; stores/syscall give two beats.
// Beats that the core ignores (execute while a load waits, stray reply) give no result.
// Reset (rst, synchronous): registers, HI, LO, PC and config cleared to zero.
`default_nettype none
module mips_integer_core_step import mic_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [31:0] instruction_word,
  input  wire logic [31:0] read_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [31:0]      address,
  output logic [31:0]      write_data,
  output logic [3:0]       byte_enable,
  output logic             last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic       cfg_we, in_fire, out_fire, rdy;
  logic [1:0] kind_chk;
  logic [31:0] start_address, initial_stack_pointer, initial_global_pointer;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;
  assign in_fire  = in_valid && rdy;
  assign out_fire = out_valid && out_ready;
  assign in_ready = rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= '0; initial_stack_pointer <= '0; initial_global_pointer <= '0;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_START: start_address <= pwdata;
        REG_SP:    initial_stack_pointer <= pwdata;
        REG_GP:    initial_global_pointer <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_START: prdata = start_address;
      REG_SP:    prdata = initial_stack_pointer;
      REG_GP:    prdata = initial_global_pointer;
      default:   prdata = '0;
    endcase
  end

  mic_ctrl u_ctrl (
    .clk, .rst, .in_fire, .action, .stat, .out_fire, .cmd,
    .in_ready(rdy), .out_valid
  );

  mic_datapath u_dp (
    .clk, .rst, .cmd, .stat, .cfg_we, .cfg_idx(paddr[3:2]), .cfg_val(pwdata),
    .instruction_word, .read_data, .r_kind(kind), .r_address(address),
    .r_write_data(write_data), .r_byte_enable(byte_enable), .r_last(last),
    .r2_kind_unused(kind_chk)
  );

  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_store_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind_chk == KIND_STORE) |-> !last) else $error("store beat marked last");
  a_load_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_LOAD) |-> last) else $error("load beat not last");
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the MIPS I integer core: driver, monitor and predictor.
`timescale 1ns / 1ps
module tb_top;
  import mic_pkg::*;

  localparam logic [5:0] OP_SPECIAL = 6'd0,  OP_REGIMM = 6'd1,  OP_J     = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3,  OP_BEQ    = 6'd4,  OP_BNE   = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6,  OP_BGTZ   = 6'd7,  OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9,  OP_SLTI   = 6'd10, OP_SLTIU = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12, OP_ORI    = 6'd13, OP_XORI  = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15, OP_BEQL   = 6'd20, OP_BNEL  = 6'd21;
  localparam logic [5:0] OP_BLEZL   = 6'd22, OP_LB     = 6'd32, OP_LH    = 6'd33;
  localparam logic [5:0] OP_LWL     = 6'd34, OP_LW     = 6'd35, OP_LBU   = 6'd36;
  localparam logic [5:0] OP_LHU     = 6'd37, OP_LWR    = 6'd38, OP_SB    = 6'd40;
  localparam logic [5:0] OP_SH      = 6'd41, OP_SWL    = 6'd42, OP_SW    = 6'd43;
  localparam logic [5:0] OP_SWR     = 6'd46, OP_UNUSED = 6'd63;

  localparam logic [5:0] F_SLL  = 6'd0,  F_SRL  = 6'd2,  F_SRA   = 6'd3,  F_SLLV  = 6'd4;
  localparam logic [5:0] F_SRLV = 6'd6,  F_SRAV = 6'd7,  F_JR    = 6'd8,  F_JALR  = 6'd9;
  localparam logic [5:0] F_SYSCALL = 6'd12, F_MFHI = 6'd16, F_MTHI = 6'd17, F_MFLO = 6'd18;
  localparam logic [5:0] F_MTLO = 6'd19, F_MULT = 6'd24, F_MULTU = 6'd25, F_DIV   = 6'd26;
  localparam logic [5:0] F_DIVU = 6'd27, F_ADD  = 6'd32, F_ADDU  = 6'd33, F_SUB   = 6'd34;
  localparam logic [5:0] F_SUBU = 6'd35, F_AND  = 6'd36, F_OR    = 6'd37, F_XOR   = 6'd38;
  localparam logic [5:0] F_NOR  = 6'd39, F_SLT  = 6'd42, F_SLTU  = 6'd43;

  localparam logic [4:0] RI_BLTZ = 5'd0, RI_BGEZ = 5'd1, RI_BLTZAL = 5'd16, RI_BGEZAL = 5'd17;

  localparam logic [2:0] LF_LB = 3'd0, LF_LH = 3'd1, LF_LWL = 3'd2, LF_LBU = 3'd4;
  localparam logic [2:0] LF_LHU = 3'd5, LF_LWR = 3'd6;

  localparam logic ACT_EXEC = 1'b0, ACT_REPLY = 1'b1;

  typedef struct {
    logic        act;
    logic [31:0] iw;
    logic [31:0] rdat;
  } in_beat_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [3:0]  be;
    logic        last;
  } mem_beat_t;

  logic clk = 1'b0, rst = 1'b1;
  logic in_valid = 1'b0, action = 1'b0, out_ready = 1'b0;
  logic [31:0] instruction_word = '0, read_data = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire in_ready, out_valid, last, pready;
  wire [1:0] kind;
  wire [31:0] address, write_data, prdata;
  wire [3:0] byte_enable;

  mips_integer_core_step DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .instruction_word(instruction_word), .read_data(read_data), .out_valid(out_valid),
    .out_ready(out_ready), .kind(kind), .address(address), .write_data(write_data),
    .byte_enable(byte_enable), .last(last), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial forever #5 clk = ~clk;

  in_beat_t  insn_q[$];
  mem_beat_t bus_q[$];
  int errors = 0;
  bit no_idle = 0;
  bit gen_wait = 0;

  // shadow architectural state
  logic [31:0] gpr[32];
  logic [31:0] hi_q, lo_q, pc_q, slot_tgt;
  logic        slot_pend, ld_wait;
  logic [4:0]  ld_dst;
  logic [2:0]  ld_fmt;
  logic [1:0]  ld_off;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic logic [31:0] sx16(logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic logic [31:0] merge_load(logic [31:0] d, logic [31:0] old);
    logic [7:0]  by;
    logic [15:0] hw;
    int k;
    k = ld_off;
    by = 8'(d >> (24 - 8 * k));
    hw = ld_off[1] ? d[15:0] : d[31:16];
    case (ld_fmt)
      LF_LB:  return {{24{by[7]}}, by};
      LF_LH:  return sx16(hw);
      LF_LWL: return (k == 0) ? d : ((d << (8 * k)) | (old & (32'hFFFFFFFF >> (32 - 8 * k))));
      LF_LBU: return {24'd0, by};
      LF_LHU: return {16'd0, hw};
      LF_LWR: return (k == 3) ? d : ((d >> (24 - 8 * k)) | (old & ~(32'hFFFFFFFF >> (24 - 8 * k))));
      default: return d;
    endcase
  endfunction

  task automatic wr(logic [4:0] r, logic [31:0] v);
    if (r != 5'd0) gpr[r] = v;
  endtask

  task automatic push_beat(logic [1:0] kd, logic [31:0] ad, logic [31:0] wd, logic [3:0] be,
                           logic lst);
    mem_beat_t e;
    e.kind = kd; e.addr = ad; e.wdata = wd; e.be = be; e.last = lst;
    bus_q.push_back(e);
  endtask

  task automatic core_divide(logic [31:0] a, logic [31:0] b, bit sgn);
    logic [31:0] ua, ub, q, r;
    if (b == 0) return;
    if (!sgn) begin
      lo_q = a / b; hi_q = a % b;
      return;
    end
    ua = a[31] ? -a : a;
    ub = b[31] ? -b : b;
    q = ua / ub; r = ua % ub;
    lo_q = (a[31] != b[31]) ? -q : q;
    hi_q = a[31] ? -r : r;
  endtask

  task automatic core_reset();
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    hi_q = '0; lo_q = '0; pc_q = '0; slot_tgt = '0;
    slot_pend = 0; ld_wait = 0; ld_dst = '0; ld_fmt = '0; ld_off = '0;
  endtask

  task automatic predict_core(in_beat_t it);
    logic [5:0] op, fn;
    logic [4:0] rs, rt, rd, sa;
    logic [31:0] a, b, simm, btgt, ea, nxt, tgt, wd, cur;
    logic [15:0] imm;
    logic [63:0] p;
    logic [7:0] bt;
    logic [1:0] k, memk;
    logic [3:0] be;
    bit take, annul;
    if (it.act == ACT_REPLY) begin
      if (!ld_wait) return;
      wr(ld_dst, merge_load(it.rdat, gpr[ld_dst]));
      ld_wait = 0;
      push_beat(KIND_FETCH, pc_q, '0, '0, 1'b1);
      return;
    end
    if (ld_wait) return;
    cur = pc_q;
    nxt = slot_pend ? slot_tgt : cur + 4;
    slot_pend = 0;
    op = it.iw[31:26]; rs = it.iw[25:21]; rt = it.iw[20:16];
    rd = it.iw[15:11]; sa = it.iw[10:6]; fn = it.iw[5:0]; imm = it.iw[15:0];
    simm = sx16(imm);
    a = gpr[rs]; b = gpr[rt];
    btgt = cur + 4 + {simm[29:0], 2'b00};
    ea = a + simm; k = ea[1:0];
    take = 0; annul = 0; tgt = '0; memk = KIND_FETCH; wd = '0; be = '0;
    case (op)
      OP_SPECIAL: case (fn)
        F_SLL:  wr(rd, b << sa);
        F_SRL:  wr(rd, b >> sa);
        F_SRA:  wr(rd, $signed(b) >>> sa);
        F_SLLV: wr(rd, b << a[4:0]);
        F_SRLV: wr(rd, b >> a[4:0]);
        F_SRAV: wr(rd, $signed(b) >>> a[4:0]);
        F_JR:   begin take = 1; tgt = a; end
        F_JALR: begin take = 1; tgt = a; wr(rd, cur + 8); end
        F_SYSCALL: memk = KIND_SYSCALL;
        F_MFHI: wr(rd, hi_q);
        F_MTHI: hi_q = a;
        F_MFLO: wr(rd, lo_q);
        F_MTLO: lo_q = a;
        F_MULT: begin
          p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
          hi_q = p[63:32]; lo_q = p[31:0];
        end
        F_MULTU: begin
          p = {32'd0, a} * {32'd0, b};
          hi_q = p[63:32]; lo_q = p[31:0];
        end
        F_DIV:  core_divide(a, b, 1);
        F_DIVU: core_divide(a, b, 0);
        F_ADD, F_ADDU: wr(rd, a + b);
        F_SUB, F_SUBU: wr(rd, a - b);
        F_AND:  wr(rd, a & b);
        F_OR:   wr(rd, a | b);
        F_XOR:  wr(rd, a ^ b);
        F_NOR:  wr(rd, ~(a | b));
        F_SLT:  wr(rd, ($signed(a) < $signed(b)) ? 32'd1 : 32'd0);
        F_SLTU: wr(rd, (a < b) ? 32'd1 : 32'd0);
        default: ;
      endcase
      OP_REGIMM: begin
        if (rt == RI_BLTZ || rt == RI_BLTZAL) take = a[31];
        else if (rt == RI_BGEZ || rt == RI_BGEZAL) take = !a[31];
        tgt = btgt;
        if (rt == RI_BLTZAL || rt == RI_BGEZAL) wr(R_RA, cur + 8);
      end
      OP_J, OP_JAL: begin
        take = 1;
        tgt = cur + 32'd4;
        tgt = {tgt[31:28], it.iw[25:0], 2'b00};
        if (op == OP_JAL) wr(R_RA, cur + 8);
      end
      OP_BEQ:  begin take = (a == b); tgt = btgt; end
      OP_BNE:  begin take = (a != b); tgt = btgt; end
      OP_BLEZ: begin take = (a == 0) || a[31]; tgt = btgt; end
      OP_BGTZ: begin take = !((a == 0) || a[31]); tgt = btgt; end
      OP_ADDI, OP_ADDIU: wr(rt, a + simm);
      OP_SLTI:  wr(rt, ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0);
      OP_SLTIU: wr(rt, (a < simm) ? 32'd1 : 32'd0);
      OP_ANDI:  wr(rt, a & {16'd0, imm});
      OP_ORI:   wr(rt, a | {16'd0, imm});
      OP_XORI:  wr(rt, a ^ {16'd0, imm});
      OP_LUI:   wr(rt, {imm, 16'd0});
      OP_BEQL, OP_BNEL, OP_BLEZL: begin
        if (op == OP_BEQL) take = (a == b);
        else if (op == OP_BNEL) take = (a != b);
        else take = (a == 0) || a[31];
        tgt = btgt;
        annul = !take;
      end
      OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR: begin
        memk = KIND_LOAD;
        ld_fmt = 3'(op - OP_LB);
      end
      OP_SB: begin
        memk = KIND_STORE; be = 4'd8 >> k; bt = b[7:0];
        wd = {24'd0, bt} << (24 - 8 * k);
      end
      OP_SH: begin
        memk = KIND_STORE;
        if (k[1]) begin be = 4'd3; wd = {16'd0, b[15:0]}; end
        else begin be = 4'd12; wd = {b[15:0], 16'd0}; end
      end
      OP_SWL: begin memk = KIND_STORE; be = 4'd15 >> k; wd = b >> (8 * k); end
      OP_SW:  begin memk = KIND_STORE; be = 4'd15; wd = b; end
      OP_SWR: begin
        memk = KIND_STORE; be = 4'(8'd15 << (3 - k)); wd = b << (24 - 8 * k);
      end
      default: ;
    endcase
    if (annul) nxt = nxt + 4;
    if (take) begin slot_pend = 1; slot_tgt = tgt; end
    pc_q = nxt;
    case (memk)
      KIND_LOAD: begin
        ld_wait = 1; ld_dst = rt; ld_off = k;
        push_beat(KIND_LOAD, {ea[31:2], 2'b00}, '0, '0, 1'b1);
      end
      KIND_STORE: begin
        push_beat(KIND_STORE, {ea[31:2], 2'b00}, wd, be, 1'b0);
        push_beat(KIND_FETCH, nxt, '0, '0, 1'b1);
      end
      KIND_SYSCALL: begin
        push_beat(KIND_SYSCALL, '0, gpr[R_V0], '0, 1'b0);
        push_beat(KIND_FETCH, nxt, '0, '0, 1'b1);
      end
      default: push_beat(KIND_FETCH, nxt, '0, '0, 1'b1);
    endcase
  endtask

  // ---------------- driver ----------------
  int in_gap = 0;
  function automatic int pick_gap();
    if (no_idle || $urandom_range(0, 2) != 0) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    logic nv;
    in_beat_t nx;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        predict_core('{action, instruction_word, read_data});
        nv = 1'b0;
        in_gap = pick_gap();
      end
      if (!nv) begin
        if (in_gap > 0) in_gap--;
        else if (insn_q.size() != 0) begin
          nx = insn_q.pop_front();
          action <= nx.act;
          instruction_word <= nx.iw;
          read_data <= nx.rdat;
          nv = 1'b1;
        end
      end
      in_valid <= nv;
    end
  end

  // ---------------- monitor ----------------
  int out_gap = 0;
  always @(posedge clk) begin
    mem_beat_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (bus_q.size() == 0) begin
          report_mismatch("unexpected beat, address", address, '0);
        end else begin
          e = bus_q.pop_front();
          if (kind != e.kind) report_mismatch("kind", kind, e.kind);
          if (address != e.addr) report_mismatch("address", address, e.addr);
          if (write_data != e.wdata) report_mismatch("write_data", write_data, e.wdata);
          if (byte_enable != e.be) report_mismatch("byte_enable", byte_enable, e.be);
          if (last != e.last) report_mismatch("last", last, e.last);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_gap = pick_gap();
        out_ready <= (out_gap == 0);
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [4:0] sa, logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic bit is_load(logic [31:0] iw);
    return iw[31:26] >= OP_LB && iw[31:26] <= OP_LWR;
  endfunction

  task automatic send_exec(logic [31:0] iw);
    insn_q.push_back('{ACT_EXEC, iw, $urandom()});
    if (is_load(iw)) gen_wait = 1;
  endtask

  task automatic send_reply(logic [31:0] d);
    insn_q.push_back('{ACT_REPLY, $urandom(), d});
    gen_wait = 0;
  endtask

  function automatic logic [31:0] rand_insn();
    logic [5:0] ops[31] = '{OP_SPECIAL, OP_SPECIAL, OP_SPECIAL, OP_SPECIAL, OP_REGIMM,
      OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU,
      OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_BEQL, OP_BNEL, OP_BLEZL, OP_LB, OP_LH, OP_LWL,
      OP_LW, OP_LBU, OP_LHU, OP_LWR, OP_SB, OP_SWR};
    logic [5:0] fns[27] = '{F_SLL, F_SRL, F_SRA, F_SLLV, F_SRLV, F_SRAV, F_JR, F_JALR,
      F_SYSCALL, F_MFHI, F_MTHI, F_MFLO, F_MTLO, F_MULT, F_MULTU, F_DIV, F_DIVU, F_ADD,
      F_ADDU, F_SUB, F_SUBU, F_AND, F_OR, F_XOR, F_NOR, F_SLT, F_SLTU};
    logic [5:0] more[3] = '{OP_SH, OP_SWL, OP_SW};
    logic [4:0] ris[4] = '{RI_BLTZ, RI_BGEZ, RI_BLTZAL, RI_BGEZAL};
    logic [31:0] w;
    w = $urandom();
    if ($urandom_range(0, 19) == 0) return w;
    if ($urandom_range(0, 9) == 0) w[31:26] = more[$urandom_range(0, 2)];
    else w[31:26] = ops[$urandom_range(0, 30)];
    // small register set keeps dependencies frequent
    if ($urandom_range(0, 1)) begin
      w[25:21] = 5'($urandom_range(0, 7));
      w[20:16] = 5'($urandom_range(0, 7));
      w[15:11] = 5'($urandom_range(0, 7));
    end
    if (w[31:26] == OP_SPECIAL && $urandom_range(0, 19) != 0) w[5:0] = fns[$urandom_range(0, 26)];
    if (w[31:26] == OP_REGIMM && $urandom_range(0, 9) != 0) w[20:16] = ris[$urandom_range(0, 3)];
    return w;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_START: begin pc_q = v; gpr[R_RA] = v; end
      REG_SP:    gpr[R_SP] = v;
      default:   gpr[R_GP] = v;
    endcase
  endtask

  task automatic drain();
    while (insn_q.size() != 0 || in_valid || bus_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int cnt;
    cnt = 0;
    while (cnt < n) begin
      if (gen_wait) begin
        if ($urandom_range(0, 9) == 0) send_exec(rand_insn());   // ignored while waiting
        else begin send_reply($urandom()); cnt++; end
      end else if ($urandom_range(0, 19) == 0) begin
        send_reply($urandom());                                 // stray reply
      end else begin
        send_exec(rand_insn());
        cnt++;
      end
    end
    if (gen_wait) send_reply($urandom());
  endtask

  initial begin
    logic [31:0] cfg[3];
    core_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_reg(REG_START, 32'h0040_0000);
    write_reg(REG_SP, 32'h7FFF_EFFC);
    write_reg(REG_GP, 32'h1000_8000);

    no_idle = 1;
    send_exec(enc_i(OP_LUI, 5'd0, 5'd1, 16'h8000));             // r1 = most negative
    send_exec(enc_i(OP_ADDIU, 5'd0, 5'd2, 16'hFFFF));           // r2 = -1
    send_exec(enc_r(5'd1, 5'd2, 5'd0, 5'd0, F_DIV));
    send_exec(enc_r(5'd1, 5'd0, 5'd0, 5'd0, F_DIVU));           // divide by zero
    send_exec(enc_r(5'd0, 5'd0, 5'd3, 5'd0, F_MFHI));
    send_exec(enc_r(5'd0, 5'd0, 5'd4, 5'd0, F_MFLO));
    send_exec(enc_r(5'd1, 5'd2, 5'd0, 5'd0, F_ADDU));           // write to r0 dropped
    send_exec(enc_r(5'd1, 5'd1, 5'd5, 5'd0, F_ADD));            // wraps
    send_exec(enc_r(5'd2, 5'd2, 5'd6, 5'd0, F_MULT));
    send_exec(enc_r(5'd2, 5'd2, 5'd6, 5'd0, F_MULTU));
    send_exec(enc_i(OP_LH, 5'd0, 5'd7, 16'h0001));              // misaligned halfword
    send_reply(32'hFFFF_FFFF);
    send_exec(enc_i(OP_SH, 5'd0, 5'd2, 16'h0003));
    send_exec(enc_i(OP_SW, 5'd1, 5'd2, 16'h0002));
    send_exec(32'hFFFF_FFFF);                                   // unknown opcode
    send_exec(32'h0000_0000);
    send_exec(enc_i(OP_BEQ, 5'd0, 5'd0, 16'h0002));             // branch with jump in slot
    send_exec({OP_J, 26'h3FF_FFFF});
    send_exec(enc_i(OP_BEQ, 5'd0, 5'd0, 16'h0001));             // annulled slot in slot
    send_exec(enc_i(OP_BNEL, 5'd0, 5'd0, 16'h7FFF));
    send_exec({OP_JAL, 26'h0});
    send_exec(enc_i(OP_REGIMM, 5'd0, RI_BLTZAL, 16'h8000));
    send_exec(enc_r(R_RA, 5'd0, R_RA, 5'd0, F_JALR));
    send_exec(enc_i(OP_LWR, 5'd1, 5'd8, 16'h0002));
    send_exec(enc_i(OP_ADDIU, 5'd0, 5'd9, 16'h1234));           // dropped: load waiting
    send_reply(32'h0000_0000);
    send_reply(32'h1234_5678);                                  // stray reply
    send_exec(enc_r(5'd0, 5'd0, 5'd0, 5'd0, F_SYSCALL));
    drain();
    no_idle = 0;

    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 3; i++) begin
        case (ph)
          1: cfg[i] = 32'hFFFF_FFFF;
          2: cfg[i] = 32'h0;
          default: cfg[i] = $urandom();
        endcase
      end
      write_reg(REG_START, cfg[0]);
      write_reg(REG_SP, cfg[1]);
      write_reg(REG_GP, cfg[2]);
      no_idle = (ph == 3);
      random_phase(290);
      drain();                  // sender holds until every beat has come back
    end

    if (bus_q.size() != 0) report_mismatch("beats left over", bus_q.size(), 0);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
src/mic_pkg.sv
src/mic_muldiv.sv
src/mic_datapath.sv
src/mic_ctrl.sv
src/mips_integer_core_step.sv
dv/tb_top.sv
